// ----- sv/fcbf_pkg.sv -----
// ----------------------------------------------------------------------------
// fcbf_pkg
// Shared types and constants for the flow-controlled byte FIFO.
// ----------------------------------------------------------------------------
package fcbf_pkg;

  localparam int DEPTH = 4096;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = 13;
  localparam int TOT_W = 32;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_PEEK  = 3'd1,
    CMD_POP   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_END   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

// ----- sv/flow_controlled_byte_fifo_core.sv -----
// ----------------------------------------------------------------------------
// flow_controlled_byte_fifo_core
// Byte FIFO with configurable capacity and end-of-input flag.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one command per transfer:
// write, peek, pop, read or end input. Every command produces exactly one
// result transfer on the output channel (out_valid_o/out_ready_i) with the
// command outcome plus FIFO status and running byte totals.
// Capacity is set through cfg_we_i/cfg_wdata_i; the user must write it only
// while the block is idle (the block itself does not enforce this); values above
// the 4096-byte store are treated as 4096. Each command passes through three
// steps: capture, execute (one access to the single-port-per-side byte RAM),
// then load into the output register; a new command is taken only once the
// previous one is loaded. A pending result sits in the output register
// while the next command is taken and executed; if the receiver stalls,
// that next result waits in the sequencer until the output register drains.
// Reset empties the FIFO, clears the ended flag and totals, and sets
// capacity to 4096. Store contents are not cleared.
// ----------------------------------------------------------------------------
module flow_controlled_byte_fifo_core
  import fcbf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       command_i,
  input  logic [7:0]       data_byte_i,
  input  logic [CNT_W-1:0] amount_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             accepted_o,
  output logic [7:0]       data_out_o,
  output logic [CNT_W-1:0] removed_o,
  output logic [CNT_W-1:0] buffer_count_o,
  output logic [CNT_W-1:0] remaining_o,
  output logic             stream_ended_o,
  output logic             eof_o,
  output logic [TOT_W-1:0] total_written_o,
  output logic [TOT_W-1:0] total_read_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fcbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fcbf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .data_out_o     (data_out_o),
    .removed_o      (removed_o),
    .buffer_count_o (buffer_count_o),
    .remaining_o    (remaining_o),
    .stream_ended_o (stream_ended_o),
    .eof_o          (eof_o),
    .total_written_o(total_written_o),
    .total_read_o   (total_read_o)
  );

endmodule

// ----- sv/fcbf_ram.sv -----
// ----------------------------------------------------------------------------
// fcbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcbf_ram #(
  parameter int W = 8,
  parameter int D = 4096
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fcbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcbf_ctrl
// Sequencer: take an item, execute it, then hand the result to the output.
// ----------------------------------------------------------------------------
module fcbf_ctrl
  import fcbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.out_full || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_load_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec)
    else $error("load not followed by exec");

  a_exec_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (state_q == ST_FINISH))
    else $error("exec not followed by finish state");

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!status_i.out_full || out_ready_i))
    else $error("result loaded over a pending transfer");

endmodule

// ----- sv/fcbf_dp.sv -----
// ----------------------------------------------------------------------------
// fcbf_dp
// Datapath: FIFO pointers, counters, byte store and result register.
// ----------------------------------------------------------------------------
module fcbf_dp
  import fcbf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic [2:0]       command_i,
  input  logic [7:0]       data_byte_i,
  input  logic [CNT_W-1:0] amount_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             accepted_o,
  output logic [7:0]       data_out_o,
  output logic [CNT_W-1:0] removed_o,
  output logic [CNT_W-1:0] buffer_count_o,
  output logic [CNT_W-1:0] remaining_o,
  output logic             stream_ended_o,
  output logic             eof_o,
  output logic [TOT_W-1:0] total_written_o,
  output logic [TOT_W-1:0] total_read_o
);

  logic [CNT_W-1:0] cap_q;
  logic [2:0]       cmd_q;
  logic [7:0]       byte_q;
  logic [CNT_W-1:0] amount_q;

  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ended_q, ended_d;
  logic [TOT_W-1:0] wtot_q, wtot_d;
  logic [TOT_W-1:0] rtot_q, rtot_d;

  logic             acc_q, acc_d;
  logic             rsel_q, rsel_d;
  logic [CNT_W-1:0] rem_q, rem_d;

  logic             out_valid_q;
  logic             acc_out_q;
  logic [7:0]       dout_q;
  logic [CNT_W-1:0] rem_out_q;
  logic [CNT_W-1:0] cnt_out_q;
  logic [CNT_W-1:0] room_out_q;
  logic             ended_out_q;
  logic             eof_out_q;
  logic [TOT_W-1:0] wtot_out_q;
  logic [TOT_W-1:0] rtot_out_q;

  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] room;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q    <= command_i;
      byte_q   <= data_byte_i;
      amount_q <= amount_i;
    end
  end

  assign eff_cap = (cap_q > DEPTH_CNT) ? DEPTH_CNT : cap_q;

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    ended_d   = ended_q;
    wtot_d    = wtot_q;
    rtot_d    = rtot_q;
    acc_d     = 1'b0;
    rsel_d    = 1'b0;
    rem_d     = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = head_q + count_q[PTR_W-1:0];
    ram_raddr = head_q;
    if (cmd_i.exec) begin
      unique case (cmd_q)
        CMD_WRITE: begin
          if (!ended_q && (count_q < eff_cap)) begin
            ram_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
            wtot_d  = wtot_q + TOT_W'(1);
            acc_d   = 1'b1;
          end
        end
        CMD_PEEK: begin
          ram_raddr = head_q + amount_q[PTR_W-1:0];
          if (amount_q < count_q) begin
            ram_re = 1'b1;
            acc_d  = 1'b1;
            rsel_d = 1'b1;
          end
        end
        CMD_POP: begin
          rem_d   = (amount_q < count_q) ? amount_q : count_q;
          head_d  = head_q + rem_d[PTR_W-1:0];
          count_d = count_q - rem_d;
          rtot_d  = rtot_q + TOT_W'(rem_d);
        end
        CMD_READ: begin
          if (count_q != '0) begin
            ram_re  = 1'b1;
            acc_d   = 1'b1;
            rsel_d  = 1'b1;
            rem_d   = CNT_W'(1);
            head_d  = head_q + PTR_W'(1);
            count_d = count_q - CNT_W'(1);
            rtot_d  = rtot_q + TOT_W'(1);
          end
        end
        CMD_END: ended_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      ended_q <= 1'b0;
      wtot_q  <= '0;
      rtot_q  <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      ended_q <= ended_d;
      wtot_q  <= wtot_d;
      rtot_q  <= rtot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      acc_q  <= acc_d;
      rsel_q <= rsel_d;
      rem_q  <= rem_d;
    end
  end

  fcbf_ram #(
    .W(8),
    .D(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(byte_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign room = (eff_cap > count_q) ? (eff_cap - count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      acc_out_q   <= acc_q;
      dout_q      <= rsel_q ? ram_rdata : 8'd0;
      rem_out_q   <= rem_q;
      cnt_out_q   <= count_q;
      room_out_q  <= room;
      ended_out_q <= ended_q;
      eof_out_q   <= ended_q && (count_q == '0);
      wtot_out_q  <= wtot_q;
      rtot_out_q  <= rtot_q;
    end
  end

  assign status_o.out_full = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_out_q;
  assign data_out_o        = dout_q;
  assign removed_o         = rem_out_q;
  assign buffer_count_o    = cnt_out_q;
  assign remaining_o       = room_out_q;
  assign stream_ended_o    = ended_out_q;
  assign eof_o             = eof_out_q;
  assign total_written_o   = wtot_out_q;
  assign total_read_o      = rtot_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("stored count exceeds depth");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result valid without finish");

  a_ended_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |=> ended_q)
    else $error("end-of-input flag cleared");

endmodule

// ----- tb/sv/tb_flow_controlled_byte_fifo_core.sv -----
// ----------------------------------------------------------------------------
// tb_flow_controlled_byte_fifo_core
// Self-checking testbench for the flow-controlled byte FIFO core.
// Commands go in over the input channel and a shadow FIFO predicts the status
// of each result. Results are compared field by field in arrival order.
// The test covers directed corner cases, capacity changes, a fill to a
// reduced capacity with refill, random traffic under several flow-control
// patterns, a long output stall, and end of input.
// ----------------------------------------------------------------------------
module tb_flow_controlled_byte_fifo_core;
  import fcbf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int FILL_CAP    = 64;

  typedef struct {
    logic             accepted;
    logic [7:0]       data_out;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] buffer_count;
    logic [CNT_W-1:0] remaining;
    logic             stream_ended;
    logic             eof;
    logic [TOT_W-1:0] total_written;
    logic [TOT_W-1:0] total_read;
  } fifo_status_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [2:0]       command_i;
  logic [7:0]       data_byte_i;
  logic [CNT_W-1:0] amount_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             accepted_o;
  logic [7:0]       data_out_o;
  logic [CNT_W-1:0] removed_o;
  logic [CNT_W-1:0] buffer_count_o;
  logic [CNT_W-1:0] remaining_o;
  logic             stream_ended_o;
  logic             eof_o;
  logic [TOT_W-1:0] total_written_o;
  logic [TOT_W-1:0] total_read_o;

  // shadow FIFO
  logic [7:0]       shadow_bytes [DEPTH];
  logic [PTR_W-1:0] shadow_head     = '0;
  logic [CNT_W-1:0] shadow_count    = '0;
  logic             shadow_ended    = 1'b0;
  logic [TOT_W-1:0] shadow_wr_total = '0;
  logic [TOT_W-1:0] shadow_rd_total = '0;
  logic [CNT_W-1:0] shadow_cap      = CAP_RESET;

  fifo_status_t status_q [$];
  fifo_status_t want;
  int           fail_count     = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  bit           hold_request   = 1'b0;
  int           hold_left      = 0;

  flow_controlled_byte_fifo_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .data_byte_i     (data_byte_i),
    .amount_i        (amount_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .data_out_o      (data_out_o),
    .removed_o       (removed_o),
    .buffer_count_o  (buffer_count_o),
    .remaining_o     (remaining_o),
    .stream_ended_o  (stream_ended_o),
    .eof_o           (eof_o),
    .total_written_o (total_written_o),
    .total_read_o    (total_read_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic fifo_status_t fifo_apply(logic [2:0] cmd, logic [7:0] data_byte,
                                              logic [CNT_W-1:0] amount);
    fifo_status_t     r;
    logic [CNT_W-1:0] eff_cap;
    r = '{default: '0};
    eff_cap = (shadow_cap > DEPTH_CNT) ? DEPTH_CNT : shadow_cap;
    case (cmd)
      CMD_WRITE: begin
        if (!shadow_ended && shadow_count < eff_cap) begin
          shadow_bytes[PTR_W'(shadow_head + shadow_count)] = data_byte;
          shadow_count++;
          shadow_wr_total++;
          r.accepted = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (amount < shadow_count) begin
          r.data_out = shadow_bytes[PTR_W'(shadow_head + amount)];
          r.accepted = 1'b1;
        end
      end
      CMD_POP: begin
        r.removed = (amount < shadow_count) ? amount : shadow_count;
        shadow_head = PTR_W'(shadow_head + r.removed);
        shadow_count -= r.removed;
        shadow_rd_total += TOT_W'(r.removed);
      end
      CMD_READ: begin
        if (shadow_count != 0) begin
          r.data_out = shadow_bytes[shadow_head];
          r.accepted = 1'b1;
          r.removed = CNT_W'(1);
          shadow_head = PTR_W'(shadow_head + 1);
          shadow_count--;
          shadow_rd_total++;
        end
      end
      CMD_END: shadow_ended = 1'b1;
      default: ;
    endcase
    r.buffer_count  = shadow_count;
    r.remaining     = (eff_cap > shadow_count) ? eff_cap - shadow_count : '0;
    r.stream_ended  = shadow_ended;
    r.eof           = shadow_ended && (shadow_count == 0);
    r.total_written = shadow_wr_total;
    r.total_read    = shadow_rd_total;
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_item(logic [2:0] cmd, logic [7:0] data_byte, logic [CNT_W-1:0] amount);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= data_byte;
    amount_i    <= amount;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    status_q.insert(status_q.size(), fifo_apply(cmd, data_byte, amount));
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    int               sel;
    logic [2:0]       cmd;
    logic [CNT_W-1:0] amount;
    sel = $urandom_range(0, 99);
    amount = CNT_W'($urandom_range(0, DEPTH));
    if (sel < 40) begin
      cmd = CMD_WRITE;
    end else if (sel < 60) begin
      cmd = CMD_PEEK;
      if ($urandom_range(0, 4) != 0) amount = CNT_W'($urandom_range(0, shadow_count));
    end else if (sel < 70) begin
      cmd = CMD_POP;
      if ($urandom_range(0, 9) != 0) amount = CNT_W'($urandom_range(0, 3));
    end else if (sel < 96) begin
      cmd = CMD_READ;
    end else begin
      cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
    end
    send_item(cmd, 8'($urandom), amount);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_cap = value;
    repeat (2) @(negedge clk_i);
  endtask

  task automatic test_basic_commands();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(CMD_READ, 8'h00, '0);
    send_item(CMD_PEEK, 8'h00, '0);
    send_item(CMD_POP, 8'h00, CNT_W'(5));
    send_item(CMD_SPARE_A, 8'hFF, DEPTH_CNT);
    send_item(CMD_SPARE_B, 8'h00, '0);
    send_item(CMD_SPARE_C, 8'h55, CNT_W'(4095));
    send_item(CMD_WRITE, 8'h00, '0);
    send_item(CMD_WRITE, 8'hFF, DEPTH_CNT);
    send_item(CMD_WRITE, 8'hA5, CNT_W'(4095));
    send_item(CMD_WRITE, 8'h5A, '0);
    send_item(CMD_PEEK, 8'h00, '0);
    send_item(CMD_PEEK, 8'h00, CNT_W'(3));
    send_item(CMD_PEEK, 8'h00, CNT_W'(4));
    send_item(CMD_PEEK, 8'hFF, DEPTH_CNT);
    send_item(CMD_READ, 8'h00, '0);
    send_item(CMD_POP, 8'h00, CNT_W'(1));
    send_item(CMD_POP, 8'h00, DEPTH_CNT);
  endtask

  task automatic test_capacity_limits();
    set_capacity(CNT_W'(2));
    repeat (3) send_item(CMD_WRITE, 8'($urandom), '0);
    set_capacity('0);
    send_item(CMD_WRITE, 8'h11, '0);
    send_item(CMD_PEEK, 8'h00, CNT_W'(1));
    send_item(CMD_READ, 8'h00, '0);
    set_capacity(CNT_W'(8191));
    send_item(CMD_WRITE, 8'h22, '0);
    set_capacity(CNT_W'(5000));
    send_item(CMD_WRITE, 8'h33, '0);
    send_item(CMD_POP, 8'h00, DEPTH_CNT);
  endtask

  task automatic test_fill_to_capacity();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_capacity(CNT_W'(FILL_CAP));
    for (i = 0; i < FILL_CAP; i++) send_item(CMD_WRITE, 8'($urandom), CNT_W'($urandom));
    send_item(CMD_WRITE, 8'h3C, '0);
    send_item(CMD_PEEK, 8'h00, CNT_W'(FILL_CAP - 1));
    send_item(CMD_PEEK, 8'h00, CNT_W'(FILL_CAP));
    send_item(CMD_POP, 8'h00, CNT_W'(40));
    for (i = 0; i < 40; i++) send_item(CMD_WRITE, 8'($urandom), CNT_W'($urandom));
    repeat (8) send_item(CMD_PEEK, 8'h00, CNT_W'($urandom_range(0, FILL_CAP - 1)));
    repeat (10) send_item(CMD_READ, 8'h00, '0);
    send_item(CMD_POP, 8'h00, DEPTH_CNT);
  endtask

  task automatic test_random_traffic(int n, logic [CNT_W-1:0] cap, int s_pct, int r_pct);
    set_capacity(cap);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) send_random_item();
  endtask

  task automatic test_output_backpressure();
    int i;
    set_capacity(CAP_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    for (i = 0; i < 60; i++) begin
      if (i < 40) send_item(CMD_WRITE, 8'($urandom), '0);
      else send_random_item();
    end
    // sender waits for every result before going on
    wait_drained();
    repeat (20) send_random_item();
  endtask

  task automatic test_end_of_input();
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(CMD_WRITE, 8'h77, '0);
    send_item(CMD_END, 8'h00, '0);
    send_item(CMD_END, 8'hFF, DEPTH_CNT);
    send_item(CMD_WRITE, 8'h88, '0);
    send_item(CMD_PEEK, 8'h00, '0);
    send_item(CMD_READ, 8'h00, '0);
    send_item(CMD_POP, 8'h00, DEPTH_CNT);
    send_item(CMD_READ, 8'h00, '0);
    send_item(CMD_WRITE, 8'h99, '0);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    repeat (40) send_random_item();
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    bit rdy;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = ($urandom_range(0, 99) >= recv_stall_pct);
      end
      out_ready_i <= rdy;
    end
  end

  task automatic check_field(string name, logic [TOT_W-1:0] exp_val, logic [TOT_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        $display("%0t: result transfer with no command outstanding", $time);
        fail_count++;
      end else begin
        want = status_q[0];
        status_q.delete(0);
        check_field("accepted", TOT_W'(want.accepted), TOT_W'(accepted_o));
        check_field("data_out", TOT_W'(want.data_out), TOT_W'(data_out_o));
        check_field("removed", TOT_W'(want.removed), TOT_W'(removed_o));
        check_field("buffer_count", TOT_W'(want.buffer_count), TOT_W'(buffer_count_o));
        check_field("remaining", TOT_W'(want.remaining), TOT_W'(remaining_o));
        check_field("stream_ended", TOT_W'(want.stream_ended), TOT_W'(stream_ended_o));
        check_field("eof", TOT_W'(want.eof), TOT_W'(eof_o));
        check_field("total_written", want.total_written, total_written_o);
        check_field("total_read", want.total_read, total_read_o);
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    command_i   = CMD_WRITE;
    data_byte_i = '0;
    amount_i    = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_commands();
    test_capacity_limits();
    test_fill_to_capacity();
    test_random_traffic(60, CAP_RESET, 0, 0);
    test_random_traffic(60, CNT_W'(16), 55, 0);
    test_random_traffic(60, CNT_W'(8191), 0, 55);
    test_random_traffic(60, CNT_W'(1), 21, 21);
    test_random_traffic(60, '0, 55, 0);
    test_random_traffic(60, CNT_W'(3000), 0, 55);
    test_output_backpressure();
    test_end_of_input();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- flow_controlled_byte_fifo_core.f -----
sv/fcbf_pkg.sv
sv/fcbf_ram.sv
sv/fcbf_ctrl.sv
sv/fcbf_dp.sv
sv/flow_controlled_byte_fifo_core.sv
tb/sv/tb_flow_controlled_byte_fifo_core.sv
